// ----- sv/lmsc_pkg.sv -----
// shared types and constants for the led matrix scan controller
`default_nettype none

package lmsc_pkg;

	localparam int MATRIX_ROWS = 8;
	localparam int MATRIX_COLS = 8;
	localparam int MODE_LAMPS  = 4;

	localparam int ROW_IDX_W = $clog2(MATRIX_ROWS);
	localparam int COL_IDX_W = $clog2(MATRIX_COLS);

	localparam logic [2:0] DP_COL = 3'd7;

	localparam logic [3:0] SLOT_MODE     = 4'd8;
	localparam logic [3:0] SLOT_UNIT     = 4'd9;
	localparam logic [3:0] SLOT_UPPER_DP = 4'd10;
	localparam logic [3:0] SLOT_LOWER_DP = 4'd11;

	localparam logic [3:0] MODE_LAMP_MASK = 4'((1 << MODE_LAMPS) - 1);

	localparam logic [ROW_IDX_W-1:0] UPPER_DP_ROW = 3'd1;
	localparam logic [ROW_IDX_W-1:0] LOWER_DP_ROW = 3'd4;

	localparam logic [1:0] CFG_SCAN_PERIOD    = 2'd0;
	localparam logic [1:0] CFG_DISPLAY_ENABLE = 2'd1;

	typedef enum logic [2:0] {
		FN_TICK    = 3'd0,
		FN_ROW_CHK = 3'd1,
		FN_ROW_RAW = 3'd2,
		FN_PIXEL   = 3'd3,
		FN_CLEAR   = 3'd4,
		FN_FILL    = 3'd5
	} func_t;

	typedef struct packed {
		logic [2:0]           func;
		logic [ROW_IDX_W-1:0] row_index;
		logic [COL_IDX_W-1:0] col_index;
		logic [7:0]           row_bits;
		logic                 pixel_on;
		logic [3:0]           lamp_bits;
		logic                 dc_charging;
		logic [1:0]           unit_index;
	} req_t;

	typedef struct packed {
		logic [7:0] row_drive;
		logic [7:0] col_drive;
		logic       scan_stepped;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] index;
		logic [7:0] data;
	} cfg_wr_t;

	typedef logic [MATRIX_ROWS-1:0][MATRIX_COLS-1:0] frame_t;

endpackage

`default_nettype wire

// ----- sv/lmsc_frame.sv -----
// 8x8 frame buffer with per-row update logic
`default_nettype none

module lmsc_frame (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_s1,
	input  wire lmsc_pkg::req_t  req_s1,
	output lmsc_pkg::frame_t     frame
);

	lmsc_pkg::frame_t frame_q;
	lmsc_pkg::frame_t frame_d;

	logic in_upper;
	logic in_lower;

	assign in_upper = (req_s1.row_index >= 3'd1) && (req_s1.row_index <= 3'd3);
	assign in_lower = (req_s1.row_index >= 3'd4) && (req_s1.row_index <= 3'd6);

	always_comb begin
		frame_d = frame_q;
		if (valid_s1) begin
			for (int i = 0; i < lmsc_pkg::MATRIX_ROWS; i++) begin
				case (req_s1.func)
					lmsc_pkg::FN_ROW_CHK: begin
						// a set decimal point clears the others in its group
						if (req_s1.row_bits[lmsc_pkg::DP_COL]) begin
							if ((in_upper && i >= 1 && i <= 3) ||
							    (in_lower && i >= 4 && i <= 6)) begin
								frame_d[i][lmsc_pkg::DP_COL] = 1'b0;
							end
						end
						if (req_s1.row_index == lmsc_pkg::ROW_IDX_W'(i)) begin
							frame_d[i] = req_s1.row_bits;
						end
					end
					lmsc_pkg::FN_ROW_RAW: begin
						if (req_s1.row_index == lmsc_pkg::ROW_IDX_W'(i)) begin
							frame_d[i] = req_s1.row_bits;
						end
					end
					lmsc_pkg::FN_PIXEL: begin
						if (req_s1.row_index == lmsc_pkg::ROW_IDX_W'(i)) begin
							frame_d[i][req_s1.col_index] = req_s1.pixel_on;
						end
					end
					lmsc_pkg::FN_CLEAR: begin
						frame_d[i] = '0;
					end
					lmsc_pkg::FN_FILL: begin
						frame_d[i] = '1;
					end
					default: begin
						frame_d[i] = frame_q[i];
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else begin
			frame_q <= frame_d;
		end
	end

	assign frame = frame_q;

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && req_s1.func == lmsc_pkg::FN_CLEAR |=> frame_q == '0)
		else $error("frame not empty after clear");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> $stable(frame_q))
		else $error("frame changed without a request");

	a_one_dp_upper: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && req_s1.func == lmsc_pkg::FN_ROW_CHK && in_upper &&
		req_s1.row_bits[lmsc_pkg::DP_COL]
		|=> $countones({frame_q[1][7], frame_q[2][7], frame_q[3][7]}) == 1)
		else $error("checked write left several upper decimal points");

endmodule

`default_nettype wire

// ----- sv/lmsc_scan.sv -----
// scan slot sequencer: tick divider, slot counter and held drive masks
`default_nettype none

module lmsc_scan (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s1,
	input  wire lmsc_pkg::req_t    req_s1,
	input  wire lmsc_pkg::frame_t  frame,
	input  wire lmsc_pkg::cfg_wr_t cfg_wr,
	output lmsc_pkg::result_t      scan_next
);

	logic [7:0] period_q;
	logic       enable_q;
	logic [7:0] tick_q;
	logic [3:0] slot_q;
	logic [7:0] row_q;
	logic [7:0] col_q;

	logic [7:0] tick_inc;
	logic       due;
	logic [7:0] slot_row;
	logic [7:0] slot_col;
	logic [3:0] slot_nxt;
	logic [7:0] row_d;
	logic [7:0] col_d;
	logic [7:0] tick_d;
	logic [3:0] slot_d;
	logic       is_tick;

	assign is_tick  = valid_s1 && (req_s1.func == lmsc_pkg::FN_TICK);
	assign tick_inc = (tick_q != 8'hFF) ? tick_q + 8'd1 : tick_q;
	assign due      = is_tick && (tick_inc >= period_q);
	assign slot_nxt = (slot_q >= lmsc_pkg::SLOT_LOWER_DP) ? 4'd0 : slot_q + 4'd1;

	// drive pattern for the current slot
	always_comb begin
		slot_row = '0;
		slot_col = '0;
		if (slot_q < 4'(lmsc_pkg::MATRIX_ROWS)) begin
			slot_row = 8'd1 << slot_q[2:0];
			slot_col = frame[slot_q[2:0]];
			slot_col[lmsc_pkg::DP_COL] = 1'b0;
		end else if (slot_q == lmsc_pkg::SLOT_MODE) begin
			slot_row = 8'd1;
			slot_col = {4'd0, req_s1.lamp_bits & lmsc_pkg::MODE_LAMP_MASK};
			if (req_s1.dc_charging) begin
				slot_col[3] = 1'b1;
				slot_col[4] = 1'b1;
			end
		end else if (slot_q == lmsc_pkg::SLOT_UNIT) begin
			case (req_s1.unit_index)
				2'd0:    slot_col = 8'h20;
				2'd1:    slot_col = 8'h40;
				default: slot_col = 8'h80;
			endcase
			slot_row = (req_s1.unit_index == 2'd3) ? 8'h08 : 8'h01;
		end else if (slot_q == lmsc_pkg::SLOT_UPPER_DP) begin
			if (frame[lmsc_pkg::UPPER_DP_ROW][lmsc_pkg::DP_COL]) begin
				slot_row = 8'd1 << lmsc_pkg::UPPER_DP_ROW;
				slot_col = 8'd1 << lmsc_pkg::DP_COL;
			end else if (frame[lmsc_pkg::UPPER_DP_ROW + 3'd1][lmsc_pkg::DP_COL]) begin
				slot_row = 8'd1 << (lmsc_pkg::UPPER_DP_ROW + 3'd1);
				slot_col = 8'd1 << lmsc_pkg::DP_COL;
			end
		end else begin
			if (frame[lmsc_pkg::LOWER_DP_ROW][lmsc_pkg::DP_COL]) begin
				slot_row = 8'd1 << lmsc_pkg::LOWER_DP_ROW;
				slot_col = 8'd1 << lmsc_pkg::DP_COL;
			end else if (frame[lmsc_pkg::LOWER_DP_ROW + 3'd1][lmsc_pkg::DP_COL]) begin
				slot_row = 8'd1 << (lmsc_pkg::LOWER_DP_ROW + 3'd1);
				slot_col = 8'd1 << lmsc_pkg::DP_COL;
			end
		end
	end

	always_comb begin
		row_d  = row_q;
		col_d  = col_q;
		tick_d = tick_q;
		slot_d = slot_q;
		if (is_tick) begin
			tick_d = due ? 8'd0 : tick_inc;
		end
		if (due) begin
			if (enable_q) begin
				row_d  = slot_row;
				col_d  = slot_col;
				slot_d = slot_nxt;
			end else begin
				row_d = '0;
				col_d = '0;
			end
		end
		// disabling blanks the drives right away
		if (cfg_wr.valid && cfg_wr.index == lmsc_pkg::CFG_DISPLAY_ENABLE &&
		    !cfg_wr.data[0]) begin
			row_d = '0;
			col_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= 8'd1;
			enable_q <= 1'b1;
			tick_q   <= '0;
			slot_q   <= '0;
			row_q    <= '0;
			col_q    <= '0;
		end else begin
			if (cfg_wr.valid && cfg_wr.index == lmsc_pkg::CFG_SCAN_PERIOD) begin
				period_q <= cfg_wr.data;
			end
			if (cfg_wr.valid && cfg_wr.index == lmsc_pkg::CFG_DISPLAY_ENABLE) begin
				enable_q <= cfg_wr.data[0];
			end
			tick_q <= tick_d;
			slot_q <= slot_d;
			row_q  <= row_d;
			col_q  <= col_d;
		end
	end

	assign scan_next.row_drive    = row_d;
	assign scan_next.col_drive    = col_d;
	assign scan_next.scan_stepped = due;

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= lmsc_pkg::SLOT_LOWER_DP)
		else $error("scan slot out of range");

	a_one_row: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(row_q))
		else $error("more than one row driven");

	a_disabled_blank: assert property (@(posedge clk) disable iff (!arst_n)
		due && !enable_q |=> row_q == '0 && col_q == '0 && $stable(slot_q))
		else $error("disabled step did not blank the drives");

endmodule

`default_nettype wire

// ----- sv/led_matrix_scan_controller_top.sv -----
// top level of the led matrix scan controller: request and result registers
`default_nettype none

// Takes one request per clock: busy never rises, and every request gets exactly
// one result, strobed on done for one cycle after the input register, then the
// state update and result register. The frame buffer, slot counter and tick
// divider are updated in that state update, so back-to-back requests see each
// other's effects in order. done cannot be held off; capture result in the cycle
// it is strobed. Configuration writes are always ready (cfg_ready is tied high)
// and act on the next edge; issue them only while no request is in flight.
module led_matrix_scan_controller_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire lmsc_pkg::req_t    req,
	output logic                   done,
	output lmsc_pkg::result_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data
);

	logic               valid_s1;
	lmsc_pkg::req_t     req_s1;
	logic               valid_s2;
	lmsc_pkg::result_t  result_s2;
	lmsc_pkg::frame_t   frame;
	lmsc_pkg::result_t  scan_next;
	lmsc_pkg::cfg_wr_t  cfg_wr;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	assign cfg_wr.valid = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
		if (valid_s1) begin
			result_s2 <= scan_next;
		end
	end

	lmsc_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1),
		.frame    (frame)
	);

	lmsc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.req_s1    (req_s1),
		.frame     (frame),
		.cfg_wr    (cfg_wr),
		.scan_next (scan_next)
	);

	assign done   = valid_s2;
	assign result = result_s2;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("accepted request produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result without a request");

	a_step_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.scan_stepped |-> $past(req_s1.func) == lmsc_pkg::FN_TICK)
		else $error("scan step reported for a non-tick request");

endmodule

`default_nettype wire
